// ===== rtl/core/bitmap_slot_allocator_top_assert.svh =====
// assertion macros for the bitmap slot allocator
// expects i_clk and i_rst_n in the scope of each use
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// condition and consequence in the same cycle
`define BSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bsa_pkg.sv =====
// shared types, codes and helpers for the bitmap slot allocator
// no dependencies
package bsa_pkg;

    localparam int MAX_SLOTS     = 64;
    localparam int SLOT_W        = 6;
    localparam int OBJ_W         = 48;
    localparam int SLOT_COUNT_DEF = 64;
    localparam int ADDR_BITS_DEF  = 48;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_VISIT  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOT_BUSY = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [OBJ_W-1:0]  object_ref;
        logic [1:0]        ref_type;
        logic [SLOT_W-1:0] slot_index;
        logic [2:0]        root_class;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] result_slot;
        logic [1:0]        result_type;
        logic [OBJ_W-1:0]  result_object;
        logic [2:0]        result_root;
        logic              last;
    } t_rsp;

    // lowest set bit, picked as first non-empty octet then first bit in it
    function automatic logic [SLOT_W-1:0] find_first_set(input logic [MAX_SLOTS-1:0] vec);
        logic [2:0] grp;
        logic [2:0] bitpos;
        logic [7:0] oct;
        grp    = '0;
        bitpos = '0;
        for (int g = 7; g >= 0; g--) begin
            if (|vec[g*8 +: 8]) begin
                grp = 3'(g);
            end
        end
        oct = vec[{grp, 3'b000} +: 8];
        for (int b = 7; b >= 0; b--) begin
            if (oct[b]) begin
                bitpos = 3'(b);
            end
        end
        return {grp, bitpos};
    endfunction

endpackage

// ===== rtl/core/bitmap_slot_allocator_top.sv =====
// Bitmap slot allocator. An add, remove or clear is taken while busy is low. Busy is
// high for the one execute cycle that follows, and the single result is on o_result
// in the cycle after that, so a new transaction can be taken while that result is shown.
// A visit uses its execute cycle to snapshot the busy slots, then walks them through
// the single read port of the slot memory, one busy slot per cycle. Results come one
// per cycle, the first registered together with the first slot memory read. Busy
// stays high for the execute cycle and the whole walk. A visit with nothing stored
// gives its single EMPTY result in the cycle after its execute cycle. Every result
// is shown for exactly one cycle and must be taken then; there is no way to hold
// it off.
// depends on bsa_pkg and bitmap_slot_allocator_top_assert.svh
`include "bitmap_slot_allocator_top_assert.svh"

module bitmap_slot_allocator_top #(
    parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF,
    parameter int ADDR_BITS  = bsa_pkg::ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bsa_pkg::t_req i_req,
    output logic          busy,
    output logic          o_result_valid,
    output bsa_pkg::t_rsp o_result
);

    localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int STORE_W   = (ADDR_BITS < bsa_pkg::OBJ_W) ? ADDR_BITS : bsa_pkg::OBJ_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_VISIT = 2'd2;

    logic [1:0]            r_state, n_state;
    bsa_pkg::t_req         r_req;
    logic [SLOT_COUNT-1:0] r_free_map, n_free_map;
    logic [SLOT_COUNT-1:0] r_scan, n_scan;
    bsa_pkg::t_rsp         r_rsp, n_rsp;
    logic                  r_rsp_valid, n_rsp_valid;
    logic                  r_rsp_mem, n_rsp_mem;

    logic [STORE_W-1:0]    r_slot_mem [SLOT_COUNT];
    logic [STORE_W-1:0]    r_rd_data;

    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;

    logic [bsa_pkg::MAX_SLOTS-1:0] free_pad;
    logic [bsa_pkg::MAX_SLOTS-1:0] scan_pad;
    logic [bsa_pkg::SLOT_W-1:0]    add_idx;
    logic [bsa_pkg::SLOT_W-1:0]    vis_idx;
    logic [SLOT_COUNT-1:0]         scan_rest;
    logic                          accept;

    assign accept    = start && (r_state == ST_IDLE);
    assign free_pad  = bsa_pkg::MAX_SLOTS'(r_free_map);
    assign scan_pad  = bsa_pkg::MAX_SLOTS'(r_scan);
    assign add_idx   = bsa_pkg::find_first_set(free_pad);
    assign vis_idx   = bsa_pkg::find_first_set(scan_pad);
    assign scan_rest = r_scan & (r_scan - SLOT_COUNT'(1));

    always_comb begin
        n_state     = r_state;
        n_free_map  = r_free_map;
        n_scan      = r_scan;
        n_rsp       = '0;
        n_rsp.last  = 1'b1;
        n_rsp_valid = 1'b0;
        n_rsp_mem   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = add_idx[SLOT_BITS-1:0];
        rd_en       = 1'b0;
        rd_addr     = vis_idx[SLOT_BITS-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state     = ST_IDLE;
                n_rsp_valid = 1'b1;
                unique case (r_req.kind)
                    bsa_pkg::KIND_ADD: begin
                        if (r_free_map == '0) begin
                            n_rsp.status = bsa_pkg::STAT_FULL;
                        end else begin
                            wr_en                        = 1'b1;
                            n_free_map[add_idx[SLOT_BITS-1:0]] = 1'b0;
                            n_rsp.status                 = bsa_pkg::STAT_OK;
                            n_rsp.result_slot            = add_idx;
                            n_rsp.result_type            = r_req.ref_type;
                        end
                    end
                    bsa_pkg::KIND_REMOVE: begin
                        if ((32'(r_req.slot_index) < SLOT_COUNT)
                                && !free_pad[r_req.slot_index]) begin
                            n_free_map[r_req.slot_index[SLOT_BITS-1:0]] = 1'b1;
                            n_rsp.status = bsa_pkg::STAT_OK;
                        end else begin
                            n_rsp.status = bsa_pkg::STAT_NOT_BUSY;
                        end
                    end
                    bsa_pkg::KIND_VISIT: begin
                        n_scan = ~r_free_map;
                        if (r_free_map == '1) begin
                            n_rsp.status = bsa_pkg::STAT_EMPTY;
                        end else begin
                            // results come from the walk instead
                            n_rsp_valid = 1'b0;
                            n_state     = ST_VISIT;
                        end
                    end
                    bsa_pkg::KIND_CLEAR: begin
                        n_free_map   = '1;
                        n_rsp.status = bsa_pkg::STAT_OK;
                    end
                endcase
            end
            ST_VISIT: begin
                // one busy slot per cycle; data lands with the response register
                rd_en             = 1'b1;
                n_scan            = scan_rest;
                n_rsp_valid       = 1'b1;
                n_rsp_mem         = 1'b1;
                n_rsp.status      = bsa_pkg::STAT_OK;
                n_rsp.result_slot = vis_idx;
                n_rsp.result_root = r_req.root_class;
                n_rsp.last        = (scan_rest == '0);
                if (scan_rest == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_map  <= '1;
            r_scan      <= '0;
            r_rsp_valid <= 1'b0;
            r_rsp_mem   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_map  <= n_free_map;
            r_scan      <= n_scan;
            r_rsp_valid <= n_rsp_valid;
            r_rsp_mem   <= n_rsp_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= r_req.object_ref[STORE_W-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_slot_mem[rd_addr];
        end
    end

    always_comb begin
        o_result = r_rsp;
        if (r_rsp_mem) begin
            o_result.result_object = bsa_pkg::OBJ_W'(r_rd_data);
        end
    end

    assign o_result_valid = r_rsp_valid;
    assign busy           = (r_state != ST_IDLE);

    `BSA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
    `BSA_ASSERT_SAME(a_exec_quiet, r_state == ST_EXEC, !o_result_valid, "result in exec")
    `BSA_ASSERT_SAME(a_walk_nonempty, r_state == ST_VISIT, r_scan != '0, "walk with empty scan")
    `BSA_ASSERT_SAME(a_last_walk, r_rsp_valid && r_rsp.last, r_state != ST_VISIT, "walk past last")

endmodule
